// ===== rtl/framed_packet_receiver_crc16_macros.svh =====
// Assertion macros for the framed packet receiver.
// Each use expects clk_i and rst_ni in scope; no other dependencies.
`ifndef FRAMED_PACKET_RECEIVER_CRC16_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CRC16_MACROS_SVH

// same-cycle implication
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fpr_crc16_pkg.sv =====
// Package for the framed packet receiver: word types, codes, reset values
// and the byte-wise CRC-16/XModem update. No dependencies.
`timescale 1ns / 1ps

package fpr_crc16_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_SIZE_LIMIT    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0]  START_BYTE_RST    = 8'h00;
  localparam logic [15:0] SIZE_LIMIT_RST    = 16'd1788;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CRC       = 3'd1;
  localparam logic [2:0] ST_SEQ       = 3'd2;
  localparam logic [2:0] ST_TIMEOUT   = 3'd3;
  localparam logic [2:0] ST_LARGE     = 3'd4;
  localparam logic [2:0] ST_KNOCK     = 3'd5;
  localparam logic [2:0] ST_BAD_KNOCK = 3'd6;

  localparam logic [7:0]  KNOCK_CHAR1 = 8'h2A;  // '*'
  localparam logic [7:0]  KNOCK_CHAR2 = 8'h23;  // '#'
  localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic        ack_request;
    logic [7:0]  ack_sequence;
    logic [15:0] payload_length;
  } out_word_t;

  // CRC-16/XModem (poly 0x1021), one byte, table-free form
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    c      = {crc[7:0], crc[15:8]};
    c[7:0] = c[7:0] ^ d;
    c      = c ^ {12'h000, c[7:4]};
    c      = c ^ {c[3:0], 12'h000};
    c      = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

// ===== rtl/framed_packet_receiver_crc16.sv =====
// Framed packet receiver: start-byte hunt, size/knock/sequence parsing,
// CRC-16/XModem check and timeout. Depends on fpr_crc16_pkg and the
// assertion macros header.
//
// Each accepted input word (a received byte or a time tick) yields zero or
// one result word. It takes one word per clock cycle while in_ready_o is
// high; a word's result appears in the output register on the next cycle.
// in_ready_o is high whenever the output register is empty or is drained
// in that same cycle, so a stalled consumer holds at most one pending
// result. Data bytes of a frame are passed on as they arrive; each frame
// ends with one report word carrying status, ACK request, ACK sequence
// and payload length. Registers (APB, 4-byte stride): 0 start_byte,
// 1 size_limit, 2 timeout_ticks; write them only while the block is idle.
`timescale 1ns / 1ps
`include "framed_packet_receiver_crc16_macros.svh"

module framed_packet_receiver_crc16
  import fpr_crc16_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_SIZELO, PH_SIZEHI, PH_KNOCK1, PH_KNOCK2, PH_SEQ, PH_DATA, PH_CRC
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] size_q, size_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic [7:0]  frame_seq_q, frame_seq_d;
  logic [15:0] idle_q, idle_d;

  logic [7:0]  start_byte_q;
  logic [15:0] size_limit_q;
  logic [15:0] timeout_q;

  logic        out_valid_q;
  out_word_t   out_q;

  logic        in_fire, cfg_wr;
  logic [1:0]  reg_idx;
  logic        res_valid, report, ok_fire;
  out_word_t   res;
  logic [2:0]  rep_status;
  logic        rep_ack;
  logic [15:0] rep_len;
  logic [15:0] crc_next, idle_inc, off_inc, size_m1, size_full;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_START_BYTE:    prdata = {24'h000000, start_byte_q};
      REG_SIZE_LIMIT:    prdata = {16'h0000, size_limit_q};
      REG_TIMEOUT_TICKS: prdata = {16'h0000, timeout_q};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    crc_next  = crc16_byte(crc_q, in_word_i.rx_byte);
    idle_inc  = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
    off_inc   = offset_q + 16'd1;
    size_m1   = size_q - 16'd1;
    size_full = {in_word_i.rx_byte, size_q[7:0]};

    phase_d     = phase_q;
    offset_d    = offset_q;
    size_d      = size_q;
    crc_d       = crc_q;
    exp_seq_d   = exp_seq_q;
    frame_seq_d = frame_seq_q;
    idle_d      = idle_q;

    res_valid  = 1'b0;
    res        = '0;
    report     = 1'b0;
    ok_fire    = 1'b0;
    rep_status = ST_OK;
    rep_ack    = 1'b0;
    rep_len    = '0;

    if (in_fire) begin
      if (in_word_i.cmd == CMD_TICK) begin
        if (phase_q != PH_HUNT && phase_q != PH_SIZELO && phase_q != PH_SIZEHI) begin
          idle_d = idle_inc;
          if (idle_inc >= timeout_q) begin
            report     = 1'b1;
            rep_status = ST_TIMEOUT;
            priority if (phase_q == PH_DATA) rep_len = offset_q;
            else if (phase_q == PH_CRC)      rep_len = size_m1;
            else                             rep_len = '0;
          end
        end
      end else begin
        idle_d = '0;
        unique case (phase_q)
          PH_HUNT: begin
            if (in_word_i.rx_byte == start_byte_q) begin
              phase_d  = PH_SIZELO;
              crc_d    = '0;
              offset_d = '0;
            end
          end
          PH_SIZELO: begin
            crc_d   = crc_next;
            size_d  = {8'h00, in_word_i.rx_byte};
            phase_d = PH_SIZEHI;
          end
          PH_SIZEHI: begin
            crc_d  = crc_next;
            size_d = size_full;
            priority if (size_full == 16'd0) phase_d = PH_KNOCK1;
            else if (size_full > size_limit_q) begin
              report     = 1'b1;
              rep_status = ST_LARGE;
            end else phase_d = PH_SEQ;
          end
          PH_KNOCK1: begin
            if (in_word_i.rx_byte != KNOCK_CHAR1) begin
              report     = 1'b1;
              rep_status = ST_BAD_KNOCK;
            end else phase_d = PH_KNOCK2;
          end
          PH_KNOCK2: begin
            report     = 1'b1;
            rep_status = (in_word_i.rx_byte == KNOCK_CHAR2) ? ST_KNOCK : ST_BAD_KNOCK;
          end
          PH_SEQ: begin
            crc_d       = crc_next;
            frame_seq_d = in_word_i.rx_byte;
            offset_d    = '0;
            phase_d     = (size_q <= 16'd1) ? PH_CRC : PH_DATA;
          end
          PH_DATA: begin
            crc_d    = crc_next;
            offset_d = off_inc;
            if (off_inc >= size_m1) begin
              phase_d  = PH_CRC;
              offset_d = '0;
            end
            res_valid = 1'b1;
            res.kind  = KIND_DATA;
            res.data  = in_word_i.rx_byte;
          end
          PH_CRC: begin
            crc_d = crc_next;
            if (offset_q == 16'd0) begin
              offset_d = 16'd1;
            end else begin
              report  = 1'b1;
              rep_len = size_m1;
              priority if (crc_next != 16'd0) rep_status = ST_CRC;
              else if (frame_seq_q != exp_seq_q) rep_status = ST_SEQ;
              else begin
                rep_status = ST_OK;
                rep_ack    = 1'b1;
                ok_fire    = 1'b1;
                exp_seq_d  = exp_seq_q + 8'd1;
              end
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end

    if (report) begin
      res_valid          = 1'b1;
      res.kind           = KIND_REPORT;
      res.data           = '0;
      res.status         = rep_status;
      res.ack_request    = rep_ack;
      res.ack_sequence   = exp_seq_q;
      res.payload_length = rep_len;
      phase_d            = PH_HUNT;
      offset_d           = '0;
      idle_d             = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      offset_q     <= '0;
      size_q       <= '0;
      crc_q        <= '0;
      exp_seq_q    <= '0;
      frame_seq_q  <= '0;
      idle_q       <= '0;
      start_byte_q <= START_BYTE_RST;
      size_limit_q <= SIZE_LIMIT_RST;
      timeout_q    <= TIMEOUT_TICKS_RST;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      offset_q    <= offset_d;
      size_q      <= size_d;
      crc_q       <= crc_d;
      exp_seq_q   <= exp_seq_d;
      frame_seq_q <= frame_seq_d;
      idle_q      <= idle_d;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_START_BYTE:    start_byte_q <= pwdata[7:0];
          REG_SIZE_LIMIT:    size_limit_q <= pwdata[15:0];
          REG_TIMEOUT_TICKS: timeout_q    <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  `FPR_ASSERT_NOW(a_ack_only_ok, out_valid_q && out_q.ack_request, out_q.kind == KIND_REPORT && out_q.status == ST_OK, "ack request outside an accepted report")
  `FPR_ASSERT_NOW(a_data_clean, out_valid_q && out_q.kind == KIND_DATA, out_q.status == ST_OK && !out_q.ack_request && out_q.ack_sequence == 8'd0 && out_q.payload_length == 16'd0, "data word carries report fields")
  `FPR_ASSERT_NEXT(a_seq_inc, ok_fire, exp_seq_q == 8'($past(exp_seq_q) + 8'd1), "sequence not advanced after accepted frame")
  `FPR_ASSERT_NOW(a_idle_hunt, phase_q == PH_HUNT || phase_q == PH_SIZELO || phase_q == PH_SIZEHI, idle_q == 16'd0, "idle count running outside a frame")

endmodule

// ===== test/frame_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the framed packet receiver: follows both word channels and
// the register port, predicts each result and compares it. Uses fpr_crc16_pkg.

package frame_crc_tb_pkg;

  // CRC-16/XModem, one byte, shift-register form
  function automatic logic [15:0] crc_xmodem_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

module frame_checker
  import fpr_crc16_pkg::*;
  import frame_crc_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_word_t             in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_word_t            out_word_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [AddrWidth-1:0] paddr_i,
  input  logic [DataWidth-1:0] pwdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef enum logic [2:0] {
    P_HUNT, P_SIZE_LO, P_SIZE_HI, P_KNOCK_1, P_KNOCK_2, P_SEQ, P_DATA, P_CRC
  } phase_e;

  logic [7:0]  start_byte;
  logic [15:0] size_limit;
  logic [15:0] timeout_ticks;
  phase_e      phase;
  logic [15:0] offset;
  logic [15:0] frame_size;
  logic [15:0] crc;
  logic [15:0] idle;
  logic [7:0]  rx_seq;
  logic [7:0]  frame_seq;
  out_word_t   expected_q[$];
  int          errors;

  function automatic string show(out_word_t w);
    return $sformatf("kind %0d data %02h status %0d ack %0d seq %02h len %0d",
                     w.kind, w.data, w.status, w.ack_request, w.ack_sequence,
                     w.payload_length);
  endfunction

  function automatic out_word_t close_frame(logic [2:0] st, logic ack, logic [15:0] len);
    out_word_t r;
    r                = '0;
    r.kind           = KIND_REPORT;
    r.status         = st;
    r.ack_request    = ack;
    r.ack_sequence   = rx_seq;
    r.payload_length = len;
    phase            = P_HUNT;
    offset           = '0;
    idle             = '0;
    return r;
  endfunction

  task automatic advance(input in_word_t w, output bit got, output out_word_t r);
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] limit;
    got   = 1'b0;
    r     = '0;
    b     = w.rx_byte;
    len   = frame_size - 16'd1;
    limit = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
    if (w.cmd == CMD_TICK) begin
      if (phase >= P_KNOCK_1) begin
        if (idle != IDLE_MAX) idle = idle + 16'd1;
        if (idle >= limit) begin
          got = 1'b1;
          r   = close_frame(ST_TIMEOUT, 1'b0,
                            phase == P_DATA ? offset : (phase == P_CRC ? len : 16'd0));
        end
      end
    end else begin
      idle = '0;
      case (phase)
        P_HUNT: begin
          if (b == start_byte) begin
            phase  = P_SIZE_LO;
            crc    = '0;
            offset = '0;
          end
        end
        P_SIZE_LO: begin
          crc        = crc_xmodem_next(crc, b);
          frame_size = {8'h00, b};
          phase      = P_SIZE_HI;
        end
        P_SIZE_HI: begin
          crc              = crc_xmodem_next(crc, b);
          frame_size[15:8] = b;
          if (frame_size == 16'd0) begin
            phase = P_KNOCK_1;
          end else if (frame_size > size_limit) begin
            got = 1'b1;
            r   = close_frame(ST_LARGE, 1'b0, 16'd0);
          end else begin
            phase = P_SEQ;
          end
        end
        P_KNOCK_1: begin
          if (b != KNOCK_CHAR1) begin
            got = 1'b1;
            r   = close_frame(ST_BAD_KNOCK, 1'b0, 16'd0);
          end else begin
            phase = P_KNOCK_2;
          end
        end
        P_KNOCK_2: begin
          got = 1'b1;
          r   = close_frame(b == KNOCK_CHAR2 ? ST_KNOCK : ST_BAD_KNOCK, 1'b0, 16'd0);
        end
        P_SEQ: begin
          crc       = crc_xmodem_next(crc, b);
          frame_seq = b;
          offset    = '0;
          if (frame_size <= 16'd1) phase = P_CRC;
          else phase = P_DATA;
        end
        P_DATA: begin
          crc    = crc_xmodem_next(crc, b);
          offset = offset + 16'd1;
          if (offset >= len) begin
            phase  = P_CRC;
            offset = '0;
          end
          got    = 1'b1;
          r.kind = KIND_DATA;
          r.data = b;
        end
        default: begin
          crc = crc_xmodem_next(crc, b);
          if (offset == 16'd0) begin
            offset = 16'd1;
          end else if (crc != 16'd0) begin
            got = 1'b1;
            r   = close_frame(ST_CRC, 1'b0, len);
          end else if (frame_seq != rx_seq) begin
            got = 1'b1;
            r   = close_frame(ST_SEQ, 1'b0, len);
          end else begin
            got    = 1'b1;
            r      = close_frame(ST_OK, 1'b1, len);
            rx_seq = rx_seq + 8'd1;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bit        got;
    out_word_t r;
    out_word_t e;
    if (!rst_ni) begin
      start_byte    = START_BYTE_RST;
      size_limit    = SIZE_LIMIT_RST;
      timeout_ticks = TIMEOUT_TICKS_RST;
      phase         = P_HUNT;
      offset        = '0;
      frame_size    = '0;
      crc           = '0;
      idle          = '0;
      rx_seq        = '0;
      frame_seq     = '0;
      errors        = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("%0t unexpected word: %s", $realtime, show(out_word_i));
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_word_i.kind !== e.kind || out_word_i.data !== e.data ||
              out_word_i.status !== e.status || out_word_i.ack_request !== e.ack_request ||
              out_word_i.ack_sequence !== e.ack_sequence ||
              out_word_i.payload_length !== e.payload_length) begin
            if (errors < 10) begin
              $display("%0t mismatch\n  exp %s\n  got %s", $realtime, show(e),
                       show(out_word_i));
            end
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance(in_word_i, got, r);
        if (got) expected_q.push_back(r);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrWidth-1:2])
          REG_START_BYTE:    start_byte    = pwdata_i[7:0];
          REG_SIZE_LIMIT:    size_limit    = pwdata_i[15:0];
          REG_TIMEOUT_TICKS: timeout_ticks = pwdata_i[15:0];
          default: ;
        endcase
      end
    end
    errors_o  <= errors;
    pending_o <= expected_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the framed packet receiver bench: clock, reset, register writes,
// frame stimulus and verdict. Needs fpr_crc16_pkg and frame_checker.sv.

module testbench;
  import fpr_crc16_pkg::*;
  import frame_crc_tb_pkg::*;

  localparam int RUN_LIMIT = 1_000_000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [AddrWidth-1:0] paddr     = '0;
  logic [DataWidth-1:0] pwdata    = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  int                   errors;
  int                   pending;

  bit          calm;
  bit          hold_req;
  int          bytes_sent;
  logic [7:0]  cur_start;
  logic [15:0] cur_limit;
  logic [15:0] cur_timeout;
  logic [7:0]  next_seq;

  framed_packet_receiver_crc16 DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  frame_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin : drain
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 150;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  task automatic put_word(input logic cmd, input logic [7:0] b);
    in_word_t w;
    w.cmd     = cmd;
    w.rx_byte = b;
    if (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_BYTE) bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] sb, input logic [15:0] lim,
                               input logic [15:0] to);
    reg_write(REG_START_BYTE, 32'(sb));
    reg_write(REG_SIZE_LIMIT, 32'(lim));
    reg_write(REG_TIMEOUT_TICKS, 32'(to));
    cur_start   = sb;
    cur_limit   = lim;
    cur_timeout = to;
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    int hi;
    r  = $urandom_range(99);
    hi = (r < 80) ? 8 : ((r < 97) ? 60 : 300);
    if (hi > cur_limit) hi = cur_limit;
    return 16'($urandom_range(1, hi));
  endfunction

  // cut >= 0: stop after that many bytes and let the frame expire
  task automatic send_frame(input logic [15:0] size, input logic [7:0] seq,
                            input bit corrupt, input int cut);
    logic [7:0]  bytes_q[$];
    logic [15:0] crc;
    int          pos;
    int          n;
    int          burst;
    bytes_q = {cur_start, size[7:0], size[15:8], seq};
    for (int i = 1; i < size; i++) bytes_q.push_back(8'($urandom_range(255)));
    crc = '0;
    for (int i = 1; i < bytes_q.size(); i++) crc = crc_xmodem_next(crc, bytes_q[i]);
    bytes_q.push_back(crc[15:8]);
    bytes_q.push_back(crc[7:0]);
    if (corrupt) begin
      pos          = $urandom_range(3, bytes_q.size() - 1);
      bytes_q[pos] = bytes_q[pos] ^ (8'h01 << $urandom_range(7));
    end
    n     = (cut < 0) ? bytes_q.size() : cut;
    burst = (cur_timeout > 16'd3) ? 3 : int'(cur_timeout) - 1;
    for (int i = 0; i < n; i++) begin
      if (i > 3 && burst > 0 && $urandom_range(9) == 0) begin
        repeat ($urandom_range(1, burst)) put_word(CMD_TICK, 8'($urandom_range(255)));
      end
      put_word(CMD_BYTE, bytes_q[i]);
    end
    if (cut >= 0) repeat (cur_timeout) put_word(CMD_TICK, 8'($urandom_range(255)));
  endtask

  // bad_at: 0 clean knock, 1 wrong first char, 2 wrong second char
  task automatic send_knock(input int bad_at, input bit expire);
    logic [7:0] b;
    put_word(CMD_BYTE, cur_start);
    put_word(CMD_BYTE, 8'h00);
    put_word(CMD_BYTE, 8'h00);
    if (expire) begin
      if ($urandom_range(1)) put_word(CMD_BYTE, KNOCK_CHAR1);
      repeat (cur_timeout) put_word(CMD_TICK, 8'($urandom_range(255)));
    end else begin
      b = 8'($urandom_range(255));
      put_word(CMD_BYTE, bad_at == 1 ? (b == KNOCK_CHAR1 ? ~b : b) : KNOCK_CHAR1);
      if (bad_at != 1) begin
        put_word(CMD_BYTE, bad_at == 2 ? (b == KNOCK_CHAR2 ? ~b : b) : KNOCK_CHAR2);
      end
    end
  endtask

  task automatic send_too_large(input logic [15:0] size);
    put_word(CMD_BYTE, cur_start);
    put_word(CMD_BYTE, size[7:0]);
    put_word(CMD_BYTE, size[15:8]);
  endtask

  task automatic random_traffic(input int count);
    int          goal;
    int          pick;
    logic [15:0] size;
    logic [7:0]  seq;
    logic [7:0]  b;
    bit          bad;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        size = pick_size();
        seq  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : next_seq;
        bad  = ($urandom_range(9) == 0);
        send_frame(size, seq, bad, -1);
        if (!bad && seq == next_seq) next_seq++;
      end else if (pick < 77) begin
        send_knock(($urandom_range(7) == 0) ? 1 : (($urandom_range(7) == 0) ? 2 : 0), 1'b0);
      end else if (pick < 82 && cur_limit != 16'hFFFF) begin
        if ($urandom_range(1)) send_too_large(cur_limit + 16'd1);
        else send_too_large(16'($urandom_range(cur_limit + 1, 65535)));
      end else if (pick < 88 && cur_timeout <= 16'd600) begin
        if ($urandom_range(3) == 0) begin
          send_knock(0, 1'b1);
        end else begin
          size = pick_size();
          send_frame(size, next_seq, 1'b0, $urandom_range(3, size + 4));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1)) begin
            put_word(CMD_TICK, 8'($urandom_range(255)));
          end else begin
            b = 8'($urandom_range(255));
            put_word(CMD_BYTE, (b == cur_start) ? ~b : b);
          end
        end
      end
    end
  endtask

  initial begin
    cur_start   = START_BYTE_RST;
    cur_limit   = SIZE_LIMIT_RST;
    cur_timeout = TIMEOUT_TICKS_RST;
    next_seq    = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    random_traffic(60);
    settle();

    apply_setting(8'hA5, 16'd40, 16'd2);
    send_knock(0, 1'b0);
    send_knock(1, 1'b0);
    send_knock(0, 1'b1);         // knock expires
    send_too_large(16'd41);      // one over the limit
    send_frame(16'd1, next_seq, 1'b0, -1);
    next_seq++;
    send_frame(16'd1, next_seq + 8'd3, 1'b0, -1);
    send_frame(16'd1, next_seq, 1'b1, -1);
    settle();

    apply_setting(8'h00, 16'hFFFF, 16'hFFFF);
    random_traffic(340);
    settle();

    apply_setting(8'hFF, 16'd1, 16'd1);
    random_traffic(230);
    settle();

    apply_setting(8'h7E, 16'd300, 16'd20);
    calm     = 1'b1;
    hold_req = 1'b1;
    send_frame(16'd30, next_seq, 1'b0, -1);
    next_seq++;
    random_traffic(150);
    calm = 1'b0;
    random_traffic(190);
    settle();

    apply_setting(8'h3C, 16'd200, 16'd7);
    random_traffic(300);
    settle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
